// ===== rtl/psh_pkg.sv =====
`default_nettype none
package psh_pkg;

	localparam int unsigned HASH_W = 61;
	localparam int unsigned SYM_W = 32;
	localparam int unsigned POS_W = 13;
	localparam int unsigned MAX_LEN_DEF = 4096;
	localparam int unsigned NUM_BASES_DEF = 2;
	localparam logic [HASH_W-1:0] HASH_MOD = {HASH_W{1'b1}};
	localparam logic [HASH_W-1:0] BASE_A_RST = HASH_W'(131);
	localparam logic [HASH_W-1:0] BASE_B_RST = HASH_W'(137);

	// command codes on the input
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	// status codes on the result
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// configuration register indexes
	localparam logic CFG_BASE_A = 1'b0;
	localparam logic CFG_BASE_B = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] command;
		logic [SYM_W-1:0] symbol;
		logic [POS_W-1:0] left;
		logic [POS_W-1:0] right;
	} item_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash_a;
		logic [HASH_W-1:0] hash_b;
		logic [1:0] status;
	} result_t;

	// classified item between front and back
	typedef struct packed {
		op_t op;
		logic [SYM_W-1:0] symbol;
		logic [POS_W-1:0] right;
		logic [POS_W-1:0] left_m1;
		logic [POS_W-1:0] right_m1;
		logic [POS_W-1:0] dist_m1;
		logic left_zero;
		logic empty_span;
		logic order_bad;
	} fitem_t;

	// control from the sequencer to each hash lane
	typedef struct packed {
		logic clear;
		logic app_start;
		logic rd_first;
		logic rd_second;
		logic q_start;
		logic commit_app;
		logic commit_q;
		logic left_zero;
		logic [SYM_W-1:0] symbol;
	} ctl_t;

endpackage
`default_nettype wire

// ===== rtl/polynomial_substring_hash_core.sv =====
// two-base polynomial substring hash modulo 2^61-1
// input side is a queue: present item while full is low and raise push;
// each push with full low is one transfer. commands: clear, append, query
// result side is a queue: while empty is low the oldest result sits on
// result; raising pop takes it (one transfer per pop with empty low)
// every command gives exactly one result, in order of arrival
// configuration: cfg_valid/cfg_ready write channel, cfg_index picks base_a
// or base_b; ready is always high and writes take effect at the next edge
// flow: a two-entry front queue classifies commands; the back sequencer
// runs one command at a time. clear, no-op and rejected commands are
// answered straight from idle; an append starts both modular multipliers
// in each lane, a query first reads the prefix/power memories and then
// starts the first one; the wait is set by the 31x31 multiplier inside
// each modular multiplier (four partial products, a sum and a fold)
// reset clears the string length, running hashes and both queues, sets
// running powers to one, loads bases 131 and 137; stored prefixes need no
// clearing. a stalled receiver fills the two-entry result queue, after which the
// sequencer waits and the front queue backs up to raise full
`default_nettype none
module polynomial_substring_hash_core #(
	parameter int unsigned MAX_LEN = psh_pkg::MAX_LEN_DEF,
	parameter int unsigned NUM_BASES = psh_pkg::NUM_BASES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire psh_pkg::item_t item,
	output logic empty,
	input wire logic pop,
	output psh_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [psh_pkg::HASH_W-1:0] cfg_data
);
	localparam int unsigned ADDR_W = $clog2(MAX_LEN);

	logic [psh_pkg::HASH_W-1:0] base_a_q, base_b_q, cfg_red;
	logic head_valid, take, lane_done, done_a, done_b;
	psh_pkg::fitem_t head;
	psh_pkg::ctl_t ctl;
	logic [ADDR_W-1:0] rd_addr, pw_addr, wr_addr;
	logic [psh_pkg::HASH_W-1:0] hash_a, hash_b;

	// base registers, all-ones reduces to zero
	assign cfg_ready = 1'b1;
	assign cfg_red = (cfg_data == psh_pkg::HASH_MOD) ? '0 : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_a_q <= psh_pkg::BASE_A_RST;
			base_b_q <= psh_pkg::BASE_B_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psh_pkg::CFG_BASE_A: base_a_q <= cfg_red;
				psh_pkg::CFG_BASE_B: base_b_q <= cfg_red;
				default: ;
			endcase
		end
	end

	// front: accept and classify
	psh_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .item(item), .full(full),
		.take(take), .head_valid(head_valid), .head(head)
	);

	// back: sequencer and result queue
	psh_back #(.MAX_LEN(MAX_LEN), .ADDR_W(ADDR_W)) u_back (
		.clk(clk), .arst_n(arst_n), .head_valid(head_valid), .head(head),
		.take(take), .ctl(ctl), .rd_addr(rd_addr), .pw_addr(pw_addr),
		.wr_addr(wr_addr), .lane_done(lane_done), .lane_hash_a(hash_a),
		.lane_hash_b(hash_b), .pop(pop), .empty(empty), .result(result)
	);

	// lanes run in lockstep
	assign lane_done = done_a | done_b;

	// first base lane always present
	psh_lane #(.DEPTH(MAX_LEN), .ADDR_W(ADDR_W)) u_lane_a (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .rd_addr(rd_addr),
		.pw_addr(pw_addr), .wr_addr(wr_addr), .base(base_a_q),
		.done(done_a), .hash(hash_a)
	);

	// second base lane only with two or more bases
	if (NUM_BASES > 1) begin : g_lane_b
		psh_lane #(.DEPTH(MAX_LEN), .ADDR_W(ADDR_W)) u_lane_b (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .rd_addr(rd_addr),
			.pw_addr(pw_addr), .wr_addr(wr_addr), .base(base_b_q),
			.done(done_b), .hash(hash_b)
		);
	end else begin : g_no_lane_b
		assign done_b = 1'b0;
		assign hash_b = '0;
	end
endmodule
`default_nettype wire

// ===== rtl/psh_mulmod.sv =====
`default_nettype none
module psh_mulmod (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [psh_pkg::HASH_W-1:0] a,
	input wire logic [psh_pkg::HASH_W-1:0] b,
	output logic done,
	output logic [psh_pkg::HASH_W-1:0] product
);
	// step counter codes: one partial product per multiply step, then a sum and a fold
	localparam logic [2:0] STEP_IDLE = 3'd0;
	localparam logic [2:0] STEP_LL = 3'd1;
	localparam logic [2:0] STEP_HL = 3'd2;
	localparam logic [2:0] STEP_LH = 3'd3;
	localparam logic [2:0] STEP_HH = 3'd4;
	localparam logic [2:0] STEP_SUM = 3'd5;
	localparam logic [2:0] STEP_FOLD = 3'd6;

	logic [2:0] step_q;
	logic done_q;
	logic [psh_pkg::HASH_W-1:0] a_q, b_q, product_q;
	logic [61:0] pp_q;
	logic [62:0] cross_q;
	logic [63:0] acc_q;
	logic [30:0] opx, opy;
	logic [61:0] pp;
	logic [63:0] sum_all;
	logic [63:0] fold_r;

	always_comb begin
		case (step_q)
			STEP_LL: begin opx = a_q[30:0]; opy = b_q[30:0]; end
			STEP_HL: begin opx = {1'b0, a_q[60:31]}; opy = b_q[30:0]; end
			STEP_LH: begin opx = a_q[30:0]; opy = {1'b0, b_q[60:31]}; end
			default: begin opx = {1'b0, a_q[60:31]}; opy = {1'b0, b_q[60:31]}; end
		endcase
		pp = 62'(opx) * 62'(opy);
		sum_all = acc_q + {1'b0, pp_q, 1'b0} + 64'(cross_q[62:30])
			+ {3'b0, cross_q[29:0], 31'b0};
		fold_r = 64'(acc_q[63:61]) + 64'(acc_q[60:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (step_q)
				STEP_IDLE: if (start) step_q <= STEP_LL;
				STEP_FOLD: begin
					step_q <= STEP_IDLE;
					done_q <= 1'b1;
				end
				default: step_q <= step_q + 3'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && step_q == STEP_IDLE) begin
			a_q <= a;
			b_q <= b;
		end
		if (step_q != STEP_IDLE) pp_q <= pp;
		case (step_q)
			STEP_HL: acc_q <= 64'(pp_q);
			STEP_LH: cross_q <= 63'(pp_q);
			STEP_HH: cross_q <= cross_q + 63'(pp_q);
			STEP_SUM: acc_q <= sum_all;
			STEP_FOLD: product_q <= (fold_r >= 64'(psh_pkg::HASH_MOD))
				? 61'(fold_r - 64'(psh_pkg::HASH_MOD)) : fold_r[60:0];
			default: ;
		endcase
	end

	assign done = done_q;
	assign product = product_q;
endmodule
`default_nettype wire

// ===== rtl/psh_lane.sv =====
`default_nettype none
module psh_lane #(
	parameter int unsigned DEPTH = psh_pkg::MAX_LEN_DEF,
	parameter int unsigned ADDR_W = $clog2(psh_pkg::MAX_LEN_DEF)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire psh_pkg::ctl_t ctl,
	input wire logic [ADDR_W-1:0] rd_addr,
	input wire logic [ADDR_W-1:0] pw_addr,
	input wire logic [ADDR_W-1:0] wr_addr,
	input wire logic [psh_pkg::HASH_W-1:0] base,
	output logic done,
	output logic [psh_pkg::HASH_W-1:0] hash
);
	localparam int unsigned HW = psh_pkg::HASH_W;

	logic [HW-1:0] prefix_mem [DEPTH];
	logic [HW-1:0] power_mem [DEPTH];
	logic [HW-1:0] rh_q, rp_q, prd_q, pwd_q, hl_q, pw_q, hr_q, res_q;
	logic [HW-1:0] p0, p1, new_rh, diff;
	logic [HW:0] sum_w, diff_w;
	logic d0, d1;

	psh_mulmod u_mul0 (
		.clk(clk), .arst_n(arst_n), .start(ctl.app_start | ctl.q_start),
		.a(ctl.app_start ? rh_q : hl_q), .b(ctl.app_start ? base : pw_q),
		.done(d0), .product(p0)
	);
	psh_mulmod u_mul1 (
		.clk(clk), .arst_n(arst_n), .start(ctl.app_start),
		.a(rp_q), .b(base), .done(d1), .product(p1)
	);

	always_comb begin
		sum_w = {1'b0, p0} + (HW+1)'(ctl.symbol);
		new_rh = (sum_w >= {1'b0, psh_pkg::HASH_MOD})
			? HW'(sum_w - {1'b0, psh_pkg::HASH_MOD}) : sum_w[HW-1:0];
		diff_w = (hr_q >= p0) ? ({1'b0, hr_q} - {1'b0, p0})
			: ({1'b0, hr_q} + {1'b0, psh_pkg::HASH_MOD} - {1'b0, p0});
		diff = diff_w[HW-1:0];
	end

	// both multipliers run in lockstep on an append, a query uses only the first
	assign done = d0 | d1;

	always_ff @(posedge clk) begin
		if (ctl.commit_app) begin
			prefix_mem[wr_addr] <= new_rh;
			power_mem[wr_addr] <= p1;
		end
		if (ctl.rd_first) begin
			prd_q <= prefix_mem[rd_addr];
			pwd_q <= power_mem[pw_addr];
		end else if (ctl.rd_second) begin
			prd_q <= prefix_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_second) begin
			hl_q <= ctl.left_zero ? '0 : prd_q;
			pw_q <= pwd_q;
		end
		if (ctl.q_start) hr_q <= prd_q;
		if (ctl.commit_app) res_q <= new_rh;
		else if (ctl.commit_q) res_q <= diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rh_q <= '0;
			rp_q <= HW'(1);
		end else if (ctl.clear) begin
			rh_q <= '0;
			rp_q <= HW'(1);
		end else if (ctl.commit_app) begin
			rh_q <= new_rh;
			rp_q <= p1;
		end
	end

	assign hash = res_q;
endmodule
`default_nettype wire

// ===== rtl/psh_front.sv =====
`default_nettype none
module psh_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire psh_pkg::item_t item,
	output logic full,
	input wire logic take,
	output logic head_valid,
	output psh_pkg::fitem_t head
);
	psh_pkg::fitem_t fq_q [2];
	psh_pkg::fitem_t cls;
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic do_push, do_take;

	// decode and precompute addresses
	always_comb begin
		unique case (item.command)
			psh_pkg::CMD_CLEAR: cls.op = psh_pkg::OP_CLEAR;
			psh_pkg::CMD_APPEND: cls.op = psh_pkg::OP_APPEND;
			psh_pkg::CMD_QUERY: cls.op = psh_pkg::OP_QUERY;
			psh_pkg::CMD_NONE: cls.op = psh_pkg::OP_NONE;
			default: cls.op = psh_pkg::OP_NONE;
		endcase
		cls.symbol = item.symbol;
		cls.right = item.right;
		cls.left_m1 = item.left - psh_pkg::POS_W'(1);
		cls.right_m1 = item.right - psh_pkg::POS_W'(1);
		cls.dist_m1 = item.right - item.left - psh_pkg::POS_W'(1);
		cls.left_zero = (item.left == '0);
		cls.empty_span = (item.left == item.right);
		cls.order_bad = (item.left > item.right);
	end

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head = fq_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_take = take & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) fq_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_take) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_take};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/psh_back.sv =====
`default_nettype none
module psh_back #(
	parameter int unsigned MAX_LEN = psh_pkg::MAX_LEN_DEF,
	parameter int unsigned ADDR_W = $clog2(psh_pkg::MAX_LEN_DEF)
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic head_valid,
	input wire psh_pkg::fitem_t head,
	output logic take,
	output psh_pkg::ctl_t ctl,
	output logic [ADDR_W-1:0] rd_addr,
	output logic [ADDR_W-1:0] pw_addr,
	output logic [ADDR_W-1:0] wr_addr,
	input wire logic lane_done,
	input wire logic [psh_pkg::HASH_W-1:0] lane_hash_a,
	input wire logic [psh_pkg::HASH_W-1:0] lane_hash_b,
	input wire logic pop,
	output logic empty,
	output psh_pkg::result_t result
);
	localparam int unsigned POS_W = psh_pkg::POS_W;
	localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
	localparam int unsigned IDX_W = (ADDR_W > POS_W) ? ADDR_W : POS_W;
	localparam int unsigned CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD2 = 5'b00010,
		S_QMUL = 5'b00100,
		S_WAIT = 5'b01000,
		S_PUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [LEN_W-1:0] len_q;
	logic is_app_q, lz_q;
	logic [POS_W-1:0] rm1_q;
	logic [psh_pkg::SYM_W-1:0] sym_q;
	logic [IDX_W-1:0] lm1_w, rm1_w, dm1_w;
	logic range_bad, at_cap;

	psh_pkg::result_t oq_q [2];
	psh_pkg::result_t push_data;
	logic oq_wr_q, oq_rd_q;
	logic [1:0] oq_cnt_q;
	logic oq_full, oq_push, oq_pop;

	assign oq_full = (oq_cnt_q == 2'd2);
	assign empty = (oq_cnt_q == 2'd0);
	assign result = oq_q[oq_rd_q];
	assign oq_pop = pop & ~empty;

	always_comb begin
		lm1_w = IDX_W'(head.left_m1);
		rm1_w = IDX_W'(rm1_q);
		dm1_w = IDX_W'(head.dist_m1);
		range_bad = head.order_bad || (CMP_W'(head.right) > CMP_W'(len_q));
		at_cap = (len_q == LEN_W'(MAX_LEN));

		state_d = state_q;
		take = 1'b0;
		oq_push = 1'b0;
		push_data = '{hash_a: '0, hash_b: '0, status: psh_pkg::ST_OK};
		ctl = '0;
		ctl.symbol = sym_q;
		ctl.left_zero = lz_q;
		rd_addr = rm1_w[ADDR_W-1:0];
		pw_addr = dm1_w[ADDR_W-1:0];
		wr_addr = len_q[ADDR_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (head_valid && !oq_full) begin
					take = 1'b1;
					unique case (head.op)
						psh_pkg::OP_CLEAR: begin
							ctl.clear = 1'b1;
							oq_push = 1'b1;
						end
						psh_pkg::OP_APPEND: begin
							if (at_cap) begin
								push_data.status = psh_pkg::ST_FULL;
								oq_push = 1'b1;
							end else begin
								ctl.app_start = 1'b1;
								state_d = S_WAIT;
							end
						end
						psh_pkg::OP_QUERY: begin
							if (range_bad) begin
								push_data.status = psh_pkg::ST_RANGE;
								oq_push = 1'b1;
							end else if (head.empty_span) begin
								oq_push = 1'b1;
							end else begin
								ctl.rd_first = 1'b1;
								rd_addr = lm1_w[ADDR_W-1:0];
								state_d = S_RD2;
							end
						end
						default: oq_push = 1'b1;
					endcase
				end
			end
			S_RD2: begin
				ctl.rd_second = 1'b1;
				state_d = S_QMUL;
			end
			S_QMUL: begin
				ctl.q_start = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (lane_done) begin
					ctl.commit_app = is_app_q;
					ctl.commit_q = ~is_app_q;
					state_d = S_PUSH;
				end
			end
			S_PUSH: begin
				push_data.hash_a = lane_hash_a;
				push_data.hash_b = lane_hash_b;
				oq_push = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			is_app_q <= (head.op == psh_pkg::OP_APPEND);
			lz_q <= head.left_zero;
			rm1_q <= head.right_m1;
			sym_q <= head.symbol;
		end
		if (oq_push) oq_q[oq_wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= '0;
			oq_wr_q <= 1'b0;
			oq_rd_q <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (ctl.clear) len_q <= '0;
			else if (ctl.commit_app) len_q <= len_q + LEN_W'(1);
			if (oq_push) oq_wr_q <= ~oq_wr_q;
			if (oq_pop) oq_rd_q <= ~oq_rd_q;
			oq_cnt_q <= oq_cnt_q + {1'b0, oq_push} - {1'b0, oq_pop};
		end
	end
endmodule
`default_nettype wire
